// ----- rtl/core/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared widths, mode codes and transaction types for the decimal writer.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // Field widths
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned ModeWidth  = 3;
  localparam int unsigned AsciiWidth = 6;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned DigitCount = 5;
  localparam int unsigned BcdWidth   = DigitCount * DigitWidth;
  localparam int unsigned StepWidth  = $clog2(ValueWidth);
  localparam int unsigned IdxWidth   = $clog2(DigitCount);

  // ASCII code of '0'
  localparam logic [AsciiWidth-1:0] AsciiZero = 6'h30;

  // Mode codes
  localparam logic [ModeWidth-1:0] ModeTrim     = 3'd0;
  localparam logic [ModeWidth-1:0] ModeFixedMin = 3'd2;
  localparam logic [ModeWidth-1:0] ModeFixedMax = 3'd5;

  // Input transaction
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [ModeWidth-1:0]  mode;
  } in_data_t;

  // Output transaction
  typedef struct packed {
    logic [AsciiWidth-1:0] ascii_digit;
    logic                  last;
  } out_data_t;

  // Converted value handed from the converter to the emitter
  typedef struct packed {
    logic [BcdWidth-1:0]  bcd;
    logic [ModeWidth-1:0] mode;
  } conv_data_t;

endpackage

// ----- rtl/core/b2da_dabble.sv -----
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module b2da_dabble (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  b2da_pkg::in_data_t    in_data_i,
  output logic                  idle_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output b2da_pkg::conv_data_t  conv_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StShift = 3'b010,
    StDone  = 3'b100
  } state_e;

  state_e                              state_q, state_d;
  logic [b2da_pkg::ValueWidth-1:0]     bin_q, bin_d;
  logic [b2da_pkg::BcdWidth-1:0]       bcd_q, bcd_d;
  logic [b2da_pkg::BcdWidth-1:0]       bcd_adj;
  logic [b2da_pkg::ModeWidth-1:0]      mode_q, mode_d;
  logic [b2da_pkg::StepWidth-1:0]      step_q, step_d;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::DigitCount; i++) begin
      if (bcd_q[i*b2da_pkg::DigitWidth +: b2da_pkg::DigitWidth] >= 4'd5) begin
        bcd_adj[i*b2da_pkg::DigitWidth +: b2da_pkg::DigitWidth] =
          bcd_q[i*b2da_pkg::DigitWidth +: b2da_pkg::DigitWidth] + 4'd3;
      end else begin
        bcd_adj[i*b2da_pkg::DigitWidth +: b2da_pkg::DigitWidth] =
          bcd_q[i*b2da_pkg::DigitWidth +: b2da_pkg::DigitWidth];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    mode_d  = mode_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          bin_d   = in_data_i.value;
          mode_d  = in_data_i.mode;
          bcd_d   = '0;
          step_d  = '0;
          state_d = StShift;
        end
      end
      StShift: begin
        bcd_d  = {bcd_adj[b2da_pkg::BcdWidth-2:0], bin_q[b2da_pkg::ValueWidth-1]};
        bin_d  = {bin_q[b2da_pkg::ValueWidth-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == b2da_pkg::StepWidth'(b2da_pkg::ValueWidth - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    mode_q <= mode_d;
    step_q <= step_d;
  end

  assign idle_o      = (state_q == StIdle);
  assign valid_o     = (state_q == StDone);
  assign conv_o.bcd  = bcd_q;
  assign conv_o.mode = mode_q;

endmodule

// ----- rtl/core/b2da_emit.sv -----
// ----------------------------------------------------------------------------
// Decimal digit emitter
// Picks digit count from mode; sends one ASCII digit per cycle while ready.
// ----------------------------------------------------------------------------
module b2da_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b2da_pkg::conv_data_t  conv_i,
  input  logic                  conv_valid_i,
  output logic                  conv_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output b2da_pkg::out_data_t   out_data_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  localparam int unsigned DW = b2da_pkg::DigitWidth;

  state_e                          state_q, state_d;
  logic [b2da_pkg::BcdWidth-1:0]   bcd_q, bcd_d;
  logic [b2da_pkg::IdxWidth-1:0]   idx_q, idx_d;
  logic [b2da_pkg::ModeWidth-1:0]  count;
  logic [DW-1:0]                   digit;
  logic                            slot_free;
  logic                            load;
  logic                            out_valid_q, out_valid_d;
  b2da_pkg::out_data_t             out_data_q, out_data_d;

  // Number of digits to send for the incoming value
  always_comb begin
    if (conv_i.mode == b2da_pkg::ModeTrim) begin
      priority if (conv_i.bcd[4*DW +: DW] != '0) count = 3'd5;
      else if (conv_i.bcd[3*DW +: DW] != '0)     count = 3'd4;
      else if (conv_i.bcd[2*DW +: DW] != '0)     count = 3'd3;
      else if (conv_i.bcd[1*DW +: DW] != '0)     count = 3'd2;
      else                                       count = 3'd1;
    end else if (conv_i.mode >= b2da_pkg::ModeFixedMin &&
                 conv_i.mode <= b2da_pkg::ModeFixedMax) begin
      count = conv_i.mode;
    end else begin
      count = 3'd0;
    end
  end

  // Current digit
  always_comb begin
    unique case (idx_q)
      3'd0:    digit = bcd_q[0*DW +: DW];
      3'd1:    digit = bcd_q[1*DW +: DW];
      3'd2:    digit = bcd_q[2*DW +: DW];
      3'd3:    digit = bcd_q[3*DW +: DW];
      3'd4:    digit = bcd_q[4*DW +: DW];
      default: digit = '0;
    endcase
  end

  assign slot_free    = !out_valid_q || out_ready_i;
  assign load         = (state_q == StEmit) && slot_free;
  assign conv_ready_o = (state_q == StIdle);

  // Sequencer
  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (conv_valid_i && count != 3'd0) begin
          bcd_d   = conv_i.bcd;
          idx_d   = b2da_pkg::IdxWidth'(count - 3'd1);
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (load) begin
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register
  always_comb begin
    out_data_d = out_data_q;
    if (load) begin
      out_data_d.ascii_digit = b2da_pkg::AsciiZero + {2'b00, digit};
      out_data_d.last        = (idx_q == '0);
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bcd_q      <= bcd_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/binary_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core
// Writes a 16-bit unsigned value as ASCII decimal digits, top digit first.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one value and a mode
// per transaction. Mode 0 drops leading zeros but keeps the units digit,
// modes 2 to 5 send exactly that many low digits, other modes send nothing.
// Output channel (out_valid_o/out_ready_i/out_data_o) sends one digit per
// transaction, with last set on the final digit of a value.
// Timing: the bit-serial converter shifts one value bit per cycle, and the
// first digit passes the converter's StShift and StDone states, then the
// emitter's StEmit state and output register; further digits follow one per
// cycle while the receiver is ready. The converter takes the next value
// after its 16-step conversion and hand-off, while the emitter is still
// sending digits of the previous one.
// Reset clears all control state; no transaction is pending after it.
// A stalled receiver holds the current digit in the output register; the
// emitter waits, then the converter waits holding its finished result.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b2da_pkg::in_data_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b2da_pkg::out_data_t  out_data_o
);

  b2da_pkg::conv_data_t conv_data;
  logic                 conv_valid;
  logic                 conv_ready;
  logic                 conv_idle;
  logic                 in_accept;

  assign in_ready_o = conv_idle;
  assign in_accept  = in_valid_i && in_ready_o;

  // Bit-serial conversion
  b2da_dabble u_dabble (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .in_data_i (in_data_i),
    .idle_o    (conv_idle),
    .valid_o   (conv_valid),
    .ready_i   (conv_ready),
    .conv_o    (conv_data)
  );

  // Digit sequencing and output register
  b2da_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .conv_i       (conv_data),
    .conv_valid_i (conv_valid),
    .conv_ready_o (conv_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Converter is busy right after taking a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("input accepted while conversion in progress");

  // A finished conversion is held until the emitter takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_valid && !conv_ready |=> conv_valid && $stable(conv_data))
    else $error("converted value lost before hand-off");

  // Converter never signals idle and done together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(conv_idle && conv_valid))
    else $error("converter idle and done at once");

  // Emitted digit is always a decimal ASCII code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ascii_digit >= 6'h30 && out_data_o.ascii_digit <= 6'h39))
    else $error("emitted code is not a decimal digit");

endmodule

// ----- tb/tb_binary_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the binary to decimal ASCII core
// Feeds value/mode transactions and predicts the digit string of each one.
// Every digit that leaves the core is checked against the oldest predicted
// digit. Both sides idle at random, with one calm stretch. Partway through,
// the receiver holds off for a long time so that the core fills up and
// stalls its input. A watchdog ends the run if no transaction is seen for
// too long.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;

  localparam int unsigned Radix         = 10;
  localparam int unsigned IdlePct       = 28;
  localparam int unsigned RandomItems   = 380;
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned HoldAtItem    = 120;
  localparam int unsigned CalmFirstItem = 240;
  localparam int unsigned CalmLastItem  = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned QuietLimit    = 4000;

  // Predicts the digit string of each value and matches it against the core
  class digit_scoreboard;
    b2da_pkg::out_data_t digits_due[$];
    int unsigned         errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Queue the digits that an accepted value must produce; returns their count
    function int unsigned note_value(input b2da_pkg::in_data_t item);
      logic [b2da_pkg::DigitWidth-1:0] digs [b2da_pkg::DigitCount];
      int unsigned                     rest;
      int unsigned                     count;
      int unsigned                     k;
      b2da_pkg::out_data_t             digit;
      rest = 32'(item.value);
      for (k = 0; k < b2da_pkg::DigitCount - 1; k++) begin
        digs[k] = b2da_pkg::DigitWidth'(rest % Radix);
        rest    = rest / Radix;
      end
      digs[b2da_pkg::DigitCount-1] = b2da_pkg::DigitWidth'(rest);
      // leading zeros go away in trim mode, units digit always stays
      if (item.mode == b2da_pkg::ModeTrim) begin
        count = b2da_pkg::DigitCount;
        while (count > 1 && digs[count-1] == 0) count--;
      end else if (item.mode >= b2da_pkg::ModeFixedMin &&
                   item.mode <= b2da_pkg::ModeFixedMax) begin
        count = 32'(item.mode);
      end else begin
        count = 0;
      end
      for (k = 0; k < count; k++) begin
        digit.ascii_digit = b2da_pkg::AsciiZero +
                            b2da_pkg::AsciiWidth'(digs[count-1-k]);
        digit.last        = (k + 1 == count);
        digits_due.push_back(digit);
      end
      return count;
    endfunction

    task check_digit(input b2da_pkg::out_data_t got);
      b2da_pkg::out_data_t want;
      if (digits_due.size() == 0) begin
        report($sformatf("unexpected digit 0x%0h last=%0b", got.ascii_digit, got.last));
      end else begin
        want = digits_due.pop_front();
        if (got.ascii_digit !== want.ascii_digit)
          report($sformatf("ascii_digit 0x%0h, predicted 0x%0h",
                           got.ascii_digit, want.ascii_digit));
        if (got.last !== want.last)
          report($sformatf("last %0b, predicted %0b", got.last, want.last));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  b2da_pkg::in_data_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  b2da_pkg::out_data_t out_data_o;

  digit_scoreboard sb;
  bit              calm;
  bit              hold_req;

  binary_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one value, with an occasional gap first; returns its digit count
  task offer_value(input b2da_pkg::in_data_t item, output int unsigned n_digits);
    if (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_digits = sb.note_value(item);
  endtask

  task offer_pair(input logic [b2da_pkg::ValueWidth-1:0] value,
                  input logic [b2da_pkg::ModeWidth-1:0] mode);
    b2da_pkg::in_data_t item;
    int unsigned        n_digits;
    item.value = value;
    item.mode  = mode;
    offer_value(item, n_digits);
  endtask

  // Values spread over every digit length, plus the top of the range
  function automatic logic [b2da_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(5))
      0:       return b2da_pkg::ValueWidth'($urandom_range(9));
      1:       return b2da_pkg::ValueWidth'($urandom_range(99));
      2:       return b2da_pkg::ValueWidth'($urandom_range(999));
      3:       return b2da_pkg::ValueWidth'($urandom_range(9999));
      4:       return b2da_pkg::ValueWidth'($urandom_range(65535, 60000));
      default: return b2da_pkg::ValueWidth'($urandom);
    endcase
  endfunction

  // Mostly modes that print digits, sometimes one that prints nothing
  function automatic logic [b2da_pkg::ModeWidth-1:0] pick_mode();
    logic [b2da_pkg::ModeWidth-1:0] mode;
    if ($urandom_range(99) < 80) begin
      mode = b2da_pkg::ModeWidth'($urandom_range(b2da_pkg::ModeFixedMax,
                                                 b2da_pkg::ModeFixedMin - 1));
      if (mode < b2da_pkg::ModeFixedMin) mode = b2da_pkg::ModeTrim;
    end else begin
      mode = b2da_pkg::ModeTrim;
      while (mode == b2da_pkg::ModeTrim ||
             (mode >= b2da_pkg::ModeFixedMin && mode <= b2da_pkg::ModeFixedMax))
        mode = b2da_pkg::ModeWidth'($urandom_range(2**b2da_pkg::ModeWidth - 1));
    end
    return mode;
  endfunction

  // Receiver: checks every digit transaction, stalls at random or on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_digit(out_data_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("binary_to_decimal_ascii_core: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    b2da_pkg::in_data_t item;
    int unsigned        n_digits;
    int unsigned        produced;
    int                 m;
    bit                 hold_done;
    sb        = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    produced  = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every mode on a mixed value, then the edge values
    for (m = 0; m < 2**b2da_pkg::ModeWidth; m++) begin
      offer_pair(16'd12345, b2da_pkg::ModeWidth'(m));
    end
    offer_pair(16'd0, b2da_pkg::ModeTrim);
    offer_pair(16'd0, b2da_pkg::ModeFixedMax);
    offer_pair(16'd65535, b2da_pkg::ModeTrim);
    offer_pair(16'd65535, b2da_pkg::ModeFixedMax);
    offer_pair(16'd65535, b2da_pkg::ModeFixedMin);
    offer_pair(16'd9, b2da_pkg::ModeTrim);
    offer_pair(16'd10, b2da_pkg::ModeTrim);
    offer_pair(16'd100, b2da_pkg::ModeTrim);
    offer_pair(16'd9999, b2da_pkg::ModeTrim);
    offer_pair(16'd10000, b2da_pkg::ModeTrim);
    offer_pair(16'd60000, b2da_pkg::ModeFixedMax);
    offer_pair(16'd59999, b2da_pkg::ModeFixedMax);
    offer_pair(16'd1234, b2da_pkg::ModeFixedMin);
    offer_pair(16'd7, b2da_pkg::ModeFixedMax);
    offer_pair(16'd50005, b2da_pkg::ModeTrim);

    // Random values; items that print nothing are not counted
    while (produced < RandomItems) begin
      calm = (produced >= CalmFirstItem && produced < CalmLastItem);
      if (!hold_done && produced >= HoldAtItem) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      item.value = pick_value();
      item.mode  = pick_mode();
      offer_value(item, n_digits);
      if (n_digits > 0) produced++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // Drain, then give stray digits a chance to show up
    while (sb.digits_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("binary_to_decimal_ascii_core: match");
    end else begin
      $display("binary_to_decimal_ascii_core: mismatch");
    end
    $finish;
  end

endmodule
